@@ hw/rtl/mms_pkg.sv @@
`timescale 1ns / 1ps
package mms_pkg;

  localparam int MAX_DEPTH   = 64;
  localparam int ADDR_W      = $clog2(MAX_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int MIN_SEASON  = 5;
  localparam int SUM_W       = 40;
  localparam int CNT_W       = 16;
  localparam int DIV_NUM_W   = 56;
  localparam int DIV_DEN_W   = 40;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
  localparam int PADDR_W     = 5;

  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_WINDOW = 3'd1;
  localparam logic [2:0] REG_ALPHA  = 3'd2;
  localparam logic [2:0] REG_BETA   = 3'd3;
  localparam logic [2:0] REG_GAMMA  = 3'd4;
  localparam logic [2:0] REG_SEASON = 3'd5;

  typedef enum logic [1:0] {
    MODE_MA,
    MODE_EXP,
    MODE_DEXP,
    MODE_HW
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [6:0]  window;
    logic [16:0] alpha;
    logic [16:0] beta;
    logic [16:0] gamma;
    logic [6:0]  season;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_START,
    OP_FIRST,
    OP_RD,
    OP_MAUPD,
    OP_DIV,
    OP_MAFIN,
    OP_NMMUL,
    OP_NMWR,
    OP_HS,
    OP_BLA,
    OP_BLB,
    OP_BLC,
    OP_HWBUF,
    OP_COMMIT,
    OP_MFA,
    OP_MFB,
    OP_HWCOMMIT,
    OP_LOAD
  } op_e;

  // which operand set a read, blend or divide works on
  typedef enum logic [3:0] {
    T_MA,
    T_NM,
    T_HW,
    T_Q1,
    T_Q2,
    T_LVL_E,
    T_TRD,
    T_LVL_H,
    T_SEA
  } tag_e;

  typedef struct packed {
    op_e  op;
    tag_e tag;
    logic load_x;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic cnt_le_p;
    logic mature;
    logic nm_last;
    logic clr_last;
    logic div_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mms_div.sv @@
`timescale 1ns / 1ps
module mms_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [mms_pkg::DIV_NUM_W-1:0] num_i,
  input  logic signed [mms_pkg::DIV_DEN_W-1:0] den_i,
  output logic                                 done_o,
  output logic signed [31:0]                   quot_o,
  output logic                                 fault_o
);
  import mms_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] r_q;
  logic [DIV_NUM_W-1:0] qs_q;
  logic [DIV_DEN_W-1:0] d_q;
  logic                 neg_q;
  logic                 zden_q;
  logic                 nneg_q;
  logic                 nzero_q;

  logic [DIV_DEN_W:0]   t;
  logic                 ge;

  assign t  = {r_q, qs_q[DIV_NUM_W-1]};
  assign ge = t >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q   <= num_i[DIV_NUM_W-1] ^ den_i[DIV_DEN_W-1];
        nneg_q  <= num_i[DIV_NUM_W-1];
        nzero_q <= (num_i == '0);
        zden_q  <= (den_i == '0);
        qs_q    <= num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
        d_q     <= den_i[DIV_DEN_W-1] ? DIV_DEN_W'(-den_i) : DIV_DEN_W'(den_i);
        r_q     <= '0;
        cnt_q   <= '0;
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        r_q  <= ge ? DIV_DEN_W'(t - {1'b0, d_q}) : t[DIV_DEN_W-1:0];
        qs_q <= {qs_q[DIV_NUM_W-2:0], ge};
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // sign, saturation and divide-by-zero answer
  always_comb begin
    if (zden_q) begin
      if (nzero_q) begin
        quot_o = '0;
      end else if (nneg_q) begin
        quot_o = -32'sh8000_0000;
      end else begin
        quot_o = 32'sh7FFF_FFFF;
      end
    end else if (neg_q) begin
      if (qs_q >= DIV_NUM_W'(64'h8000_0000)) begin
        quot_o = -32'sh8000_0000;
      end else begin
        quot_o = $signed(32'(-qs_q[31:0]));
      end
    end else begin
      if (qs_q > DIV_NUM_W'(64'h7FFF_FFFF)) begin
        quot_o = 32'sh7FFF_FFFF;
      end else begin
        quot_o = $signed(qs_q[31:0]);
      end
    end
  end

  assign done_o  = done_q;
  assign fault_o = zden_q;

endmodule

@@ hw/rtl/mms_dpath.sv @@
`timescale 1ns / 1ps
module mms_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mms_pkg::cfg_t         cfg_i,
  input  mms_pkg::cmd_t         cmd_i,
  input  logic signed [31:0]    sample_i,
  output mms_pkg::status_t      status_o,
  output logic signed [31:0]    smoothed_o,
  output logic                  mature_o,
  output logic                  fault_o
);
  import mms_pkg::*;

  logic signed [31:0]      mem [MAX_DEPTH];

  logic signed [31:0]      x_q, level_q, trend_q, nl_q, nt_q, ns_q, s_q, q_q, rd_q, y_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [ADDR_W-1:0]       rp_q, idx_q;
  logic                    mature_q, fault_q;
  logic signed [39:0]      nm_q;
  logic signed [51:0]      prod_q;
  logic signed [52:0]      acc_q;
  logic [64:0]             mf_q;
  logic                    mfneg_q;
  logic signed [31:0]      out_y_q;
  logic                    out_m_q, out_f_q;

  // divider hookup
  logic                          div_start, div_done, div_fault;
  logic signed [DIV_NUM_W-1:0]   div_num;
  logic signed [DIV_DEN_W-1:0]   div_den;
  logic signed [31:0]            div_q;

  mms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q),
    .fault_o (div_fault)
  );

  assign div_start = (cmd_i.op == OP_DIV);

  always_comb begin
    case (cmd_i.tag)
      T_MA: begin
        div_num = DIV_NUM_W'(sum_q);
        div_den = $signed(DIV_DEN_W'(cfg_i.window));
      end
      T_NM: begin
        div_num = DIV_NUM_W'(nm_q) <<< FRAC_BITS;
        div_den = DIV_DEN_W'(sum_q);
      end
      T_Q1: begin
        div_num = DIV_NUM_W'(x_q) <<< FRAC_BITS;
        div_den = DIV_DEN_W'(s_q);
      end
      default: begin
        div_num = DIV_NUM_W'(x_q) <<< FRAC_BITS;
        div_den = DIV_DEN_W'(nl_q);
      end
    endcase
  end

  // maturity points for the exponential modes
  logic [24:0] pa_full, pb_full;
  logic [8:0]  pa, pb, mp;
  assign pa_full = 25'(cfg_i.window) * 25'(cfg_i.alpha) + 25'd32768;
  assign pb_full = 25'(cfg_i.window) * 25'(cfg_i.beta) + 25'd32768;
  assign pa = pa_full[24:16];
  assign pb = pb_full[24:16];
  assign mp = (cfg_i.mode == MODE_EXP) ? pa : ((pa > pb) ? pa : pb);

  logic [CNT_W-1:0] cnt_inc;
  logic [6:0]       len;
  assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign len     = (cfg_i.mode == MODE_MA) ? cfg_i.window : cfg_i.season;

  // blend operands
  logic [16:0]        bw;
  logic signed [33:0] bold, bnew;
  always_comb begin
    case (cmd_i.tag)
      T_LVL_E: begin
        bw = cfg_i.alpha; bold = 34'(level_q); bnew = 34'(x_q);
      end
      T_TRD: begin
        bw = cfg_i.beta; bold = 34'(trend_q); bnew = 34'(nl_q) - 34'(level_q);
      end
      T_LVL_H: begin
        bw = cfg_i.alpha; bold = 34'(level_q) + 34'(trend_q); bnew = 34'(q_q);
      end
      T_SEA: begin
        bw = cfg_i.gamma; bold = 34'(s_q); bnew = 34'(q_q);
      end
      default: begin
        bw = cfg_i.alpha; bold = '0; bnew = '0;
      end
    endcase
  end

  // round half away from zero, then saturate
  logic [52:0]        bl_mag;
  logic [36:0]        bl_rnd;
  logic signed [63:0] bl_val;
  logic signed [31:0] bl_res;
  always_comb begin
    bl_mag = acc_q[52] ? 53'(-acc_q) : 53'(acc_q);
    bl_rnd = 37'((bl_mag + 53'd32768) >> WEIGHT_BITS);
    bl_val = acc_q[52] ? -$signed(64'(bl_rnd)) : $signed(64'(bl_rnd));
    bl_res = sat32(bl_val);
  end

  // output product (level + trend) * index
  logic signed [33:0] mf_a;
  logic [32:0]        ma;
  logic [31:0]        mb;
  logic [49:0]        mf_r;
  logic signed [63:0] mf_val;
  always_comb begin
    mf_a   = 34'(nl_q) + 34'(nt_q);
    ma     = mf_a[33] ? 33'(-mf_a) : 33'(mf_a);
    mb     = s_q[31] ? 32'(-33'(s_q)) : 32'(s_q);
    mf_r   = 50'(mf_q >> FRAC_BITS) + 50'(mf_q[FRAC_BITS-1]);
    mf_val = mfneg_q ? -$signed(64'(mf_r)) : $signed(64'(mf_r));
  end

  // store write port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic signed [31:0] wdata;
  always_comb begin
    we    = 1'b1;
    waddr = rp_q;
    wdata = x_q;
    case (cmd_i.op)
      OP_CLR:      begin waddr = idx_q; wdata = '0; end
      OP_MAUPD:    begin waddr = rp_q;  wdata = x_q; end
      OP_HWBUF:    begin waddr = ADDR_W'(cnt_q - 1'b1); wdata = x_q; end
      OP_NMWR:     begin waddr = idx_q; wdata = q_q; end
      OP_HWCOMMIT: begin waddr = rp_q;  wdata = ns_q; end
      default:     we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.op == OP_RD) begin
      rd_q <= mem[(cmd_i.tag == T_NM) ? idx_q : rp_q];
    end
  end

  logic idx_last_nm;
  assign idx_last_nm = ({1'b0, idx_q} == cfg_i.season - 7'd1);

  // model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      level_q  <= '0;
      trend_q  <= '0;
      cnt_q    <= '0;
      rp_q     <= '0;
      idx_q    <= '0;
      mature_q <= 1'b0;
      fault_q  <= 1'b0;
    end else begin
      if (div_done) begin
        fault_q <= fault_q | div_fault;
      end
      case (cmd_i.op)
        OP_CLR: begin
          sum_q    <= '0;
          level_q  <= '0;
          trend_q  <= '0;
          cnt_q    <= '0;
          rp_q     <= '0;
          mature_q <= 1'b0;
          idx_q    <= (idx_q == ADDR_W'(MAX_DEPTH - 1)) ? '0 : idx_q + 1'b1;
        end
        OP_START: begin
          cnt_q   <= cnt_inc;
          fault_q <= 1'b0;
          idx_q   <= '0;
          if ({1'b0, rp_q} >= len) begin
            rp_q <= '0;
          end
          if ((cfg_i.mode == MODE_EXP || cfg_i.mode == MODE_DEXP) &&
              cnt_inc == CNT_W'(mp)) begin
            mature_q <= 1'b1;
          end
        end
        OP_MAUPD: begin
          if (mature_q) begin
            sum_q <= sum_q + SUM_W'(x_q) - SUM_W'(rd_q);
          end else begin
            sum_q <= sum_q + SUM_W'(x_q);
            if (cnt_q >= CNT_W'(cfg_i.window)) begin
              mature_q <= 1'b1;
            end
          end
          rp_q <= ((7'(rp_q) + 7'd1) >= cfg_i.window) ? '0 : rp_q + 1'b1;
        end
        OP_HWBUF: sum_q <= sum_q + SUM_W'(x_q);
        OP_NMWR: begin
          if (idx_last_nm) begin
            mature_q <= 1'b1;
            rp_q     <= '0;
            idx_q    <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        OP_COMMIT: begin
          level_q <= nl_q;
          if (cfg_i.mode != MODE_EXP) begin
            trend_q <= nt_q;
          end
        end
        OP_HWCOMMIT: begin
          level_q <= nl_q;
          trend_q <= nt_q;
          rp_q    <= ((7'(rp_q) + 7'd1) >= cfg_i.season) ? '0 : rp_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_i;
    end
    if (div_done) begin
      q_q <= div_q;
    end
    case (cmd_i.op)
      OP_FIRST: begin nl_q <= x_q; nt_q <= '0; end
      OP_HS:    s_q  <= rd_q;
      OP_NMMUL: nm_q <= rd_q * $signed({1'b0, cfg_i.season});
      OP_BLA:   prod_q <= $signed({1'b0, bw}) * bold;
      OP_BLB:   acc_q <= 53'(prod_q) + $signed({1'b0, WEIGHT_ONE - bw}) * bnew;
      OP_BLC: begin
        case (cmd_i.tag)
          T_TRD:   nt_q <= bl_res;
          T_SEA:   ns_q <= bl_res;
          default: nl_q <= bl_res;
        endcase
      end
      OP_MAFIN: y_q <= q_q;
      OP_COMMIT: begin
        if (cfg_i.mode == MODE_EXP) begin
          y_q <= nl_q;
        end else begin
          y_q <= sat32(64'(nl_q) + 64'(nt_q));
        end
      end
      OP_MFA: begin
        mf_q    <= ma * mb;
        mfneg_q <= mf_a[33] ^ s_q[31];
      end
      OP_MFB: y_q <= sat32(mf_val);
      OP_LOAD: begin
        out_y_q <= y_q;
        out_m_q <= mature_q;
        out_f_q <= fault_q;
      end
      default: ;
    endcase
  end

  assign status_o.first    = (cnt_q == CNT_W'(1));
  assign status_o.cnt_le_p = (cnt_q <= CNT_W'(cfg_i.season));
  assign status_o.mature   = mature_q;
  assign status_o.nm_last  = idx_last_nm;
  assign status_o.clr_last = (idx_q == ADDR_W'(MAX_DEPTH - 1));
  assign status_o.div_done = div_done;

  assign smoothed_o = out_y_q;
  assign mature_o   = out_m_q;
  assign fault_o    = out_f_q;

endmodule

@@ hw/rtl/mms_ctrl.sv @@
`timescale 1ns / 1ps
module mms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mms_pkg::mode_e    mode_i,
  input  logic              mode_wr_i,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  input  mms_pkg::status_t  status_i,
  output mms_pkg::cmd_t     cmd_o
);
  import mms_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_START, S_BRANCH, S_FIRST, S_RD, S_MAUPD, S_DIV, S_DWAIT,
    S_MAFIN, S_NMMUL, S_NMWR, S_HS, S_BLA, S_BLB, S_BLC, S_HWBUF, S_COMMIT,
    S_MFA, S_MFB, S_HWCOM, S_DONE
  } state_e;

  state_e state_q;
  tag_e   tag_q;
  logic   mvalid_q;
  logic   fire;
  logic   can_load;

  assign s_tready_o = (state_q == S_IDLE) && !mode_wr_i;
  assign fire       = s_tvalid_i && s_tready_o;
  assign can_load   = !mvalid_q || m_tready_i;
  assign m_tvalid_o = mvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tag_q    <= T_MA;
      mvalid_q <= 1'b0;
    end else begin
      if (mvalid_q && m_tready_i) begin
        mvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (mode_wr_i) begin
            state_q <= S_CLEAR;
          end else if (fire) begin
            state_q <= S_START;
          end
        end
        S_CLEAR:  if (status_i.clr_last) state_q <= S_IDLE;
        S_START:  state_q <= S_BRANCH;
        S_BRANCH: begin
          case (mode_i)
            MODE_MA: begin
              state_q <= S_RD;
              tag_q   <= T_MA;
            end
            MODE_HW: begin
              if (status_i.first) begin
                state_q <= S_FIRST;
              end else if (status_i.cnt_le_p) begin
                state_q <= S_BLA;
                tag_q   <= T_LVL_E;
              end else begin
                state_q <= S_RD;
                tag_q   <= status_i.mature ? T_HW : T_NM;
              end
            end
            default: begin
              if (status_i.first) begin
                state_q <= S_FIRST;
              end else begin
                state_q <= S_BLA;
                tag_q   <= T_LVL_E;
              end
            end
          endcase
        end
        S_FIRST: state_q <= (mode_i == MODE_HW) ? S_HWBUF : S_COMMIT;
        S_RD: begin
          case (tag_q)
            T_MA:    state_q <= S_MAUPD;
            T_NM:    state_q <= S_NMMUL;
            default: state_q <= S_HS;
          endcase
        end
        S_MAUPD: begin
          state_q <= S_DIV;
          tag_q   <= T_MA;
        end
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (status_i.div_done) begin
            case (tag_q)
              T_MA: state_q <= S_MAFIN;
              T_NM: state_q <= S_NMWR;
              T_Q1: begin
                state_q <= S_BLA;
                tag_q   <= T_LVL_H;
              end
              default: begin
                state_q <= S_BLA;
                tag_q   <= T_SEA;
              end
            endcase
          end
        end
        S_MAFIN: state_q <= S_DONE;
        S_NMMUL: state_q <= S_DIV;
        S_NMWR: begin
          state_q <= S_RD;
          tag_q   <= status_i.nm_last ? T_HW : T_NM;
        end
        S_HS: begin
          state_q <= S_DIV;
          tag_q   <= T_Q1;
        end
        S_BLA: state_q <= S_BLB;
        S_BLB: state_q <= S_BLC;
        S_BLC: begin
          case (tag_q)
            T_LVL_E: begin
              if (mode_i == MODE_EXP) begin
                state_q <= S_COMMIT;
              end else begin
                state_q <= S_BLA;
                tag_q   <= T_TRD;
              end
            end
            T_LVL_H: begin
              state_q <= S_BLA;
              tag_q   <= T_TRD;
            end
            T_TRD: begin
              if (mode_i != MODE_HW) begin
                state_q <= S_COMMIT;
              end else if (status_i.cnt_le_p) begin
                state_q <= S_HWBUF;
              end else begin
                state_q <= S_DIV;
                tag_q   <= T_Q2;
              end
            end
            default: state_q <= S_MFA;
          endcase
        end
        S_HWBUF:  state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_DONE;
        S_MFA:    state_q <= S_MFB;
        S_MFB:    state_q <= S_HWCOM;
        S_HWCOM:  state_q <= S_DONE;
        S_DONE: begin
          if (can_load) begin
            mvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.tag    = tag_q;
    cmd_o.load_x = fire;
    case (state_q)
      S_CLEAR:  cmd_o.op = OP_CLR;
      S_START:  cmd_o.op = OP_START;
      S_FIRST:  cmd_o.op = OP_FIRST;
      S_RD:     cmd_o.op = OP_RD;
      S_MAUPD:  cmd_o.op = OP_MAUPD;
      S_DIV:    cmd_o.op = OP_DIV;
      S_MAFIN:  cmd_o.op = OP_MAFIN;
      S_NMMUL:  cmd_o.op = OP_NMMUL;
      S_NMWR:   cmd_o.op = OP_NMWR;
      S_HS:     cmd_o.op = OP_HS;
      S_BLA:    cmd_o.op = OP_BLA;
      S_BLB:    cmd_o.op = OP_BLB;
      S_BLC:    cmd_o.op = OP_BLC;
      S_HWBUF:  cmd_o.op = OP_HWBUF;
      S_COMMIT: cmd_o.op = OP_COMMIT;
      S_MFA:    cmd_o.op = OP_MFA;
      S_MFB:    cmd_o.op = OP_MFB;
      S_HWCOM:  cmd_o.op = OP_HWCOMMIT;
      S_DONE:   cmd_o.op = can_load ? OP_LOAD : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

`ifndef SYNTH
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == S_DWAIT)
    else $error("divider finished outside the wait state");

  a_fire_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> state_q == S_START)
    else $error("accepted beat did not start processing");

  a_norm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NMWR |-> mode_i == MODE_HW)
    else $error("season normalization outside Holt-Winters mode");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && can_load) |=> (m_tvalid_o && state_q == S_IDLE))
    else $error("result not presented after completion");
`endif

endmodule

@@ hw/rtl/multi_mode_series_smoother.sv @@
`timescale 1ns / 1ps
// The first Holt-Winters beat past the buffered period also normalizes every season entry.
// One beat in flight; the 56-step shared divider paces the dividing modes (zero divisor: no steps).
// rst_ni async, active low: registers to defaults, state clears, store undefined until a mode write.
// A write to the mode register runs a store clearing pass; no beat is taken then.
module multi_mode_series_smoother (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,   // [31:0] sample
  // output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,   // [31:0] smoothed
  output logic [1:0]                   m_axis_tuser_o,   // [0] mature, [1] divide_fault
  // register port
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mms_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);
  import mms_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] ridx;
  logic       mode_wr;

  assign pready_o = 1'b1;
  assign ridx     = paddr_i[4:2];
  assign wr       = psel_i && penable_i && pwrite_i && pready_o;
  assign mode_wr  = wr && (ridx == REG_MODE);

  // out-of-range window, weight and season writes leave the register unchanged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_MA;
      cfg_q.window <= 7'd8;
      cfg_q.alpha  <= 17'd32768;
      cfg_q.beta   <= 17'd32768;
      cfg_q.gamma  <= 17'd32768;
      cfg_q.season <= 7'd12;
    end else if (wr) begin
      case (ridx)
        REG_MODE: cfg_q.mode <= mode_e'(pwdata_i[1:0]);
        REG_WINDOW: begin
          if (pwdata_i >= 32'd1 && pwdata_i <= 32'(MAX_DEPTH)) begin
            cfg_q.window <= pwdata_i[6:0];
          end
        end
        REG_ALPHA:  if (pwdata_i <= 32'(WEIGHT_ONE)) cfg_q.alpha <= pwdata_i[16:0];
        REG_BETA:   if (pwdata_i <= 32'(WEIGHT_ONE)) cfg_q.beta  <= pwdata_i[16:0];
        REG_GAMMA:  if (pwdata_i <= 32'(WEIGHT_ONE)) cfg_q.gamma <= pwdata_i[16:0];
        REG_SEASON: begin
          if (pwdata_i >= 32'(MIN_SEASON) && pwdata_i <= 32'(MAX_DEPTH)) begin
            cfg_q.season <= pwdata_i[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MODE:   prdata_o = 32'(cfg_q.mode);
      REG_WINDOW: prdata_o = 32'(cfg_q.window);
      REG_ALPHA:  prdata_o = 32'(cfg_q.alpha);
      REG_BETA:   prdata_o = 32'(cfg_q.beta);
      REG_GAMMA:  prdata_o = 32'(cfg_q.gamma);
      REG_SEASON: prdata_o = 32'(cfg_q.season);
      default:    prdata_o = '0;
    endcase
  end

  cmd_t        cmd;
  status_t     status;
  logic signed [31:0] smoothed;
  logic        mature, fault;

  mms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (cfg_q.mode),
    .mode_wr_i  (mode_wr),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mms_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sample_i   ($signed(s_axis_tdata_i)),
    .status_o   (status),
    .smoothed_o (smoothed),
    .mature_o   (mature),
    .fault_o    (fault)
  );

  assign m_axis_tdata_o = smoothed;
  assign m_axis_tuser_o = {fault, mature};

endmodule

@@ dv/tb_multi_mode_series_smoother.sv @@
`timescale 1ns / 1ps
module tb_multi_mode_series_smoother;
  import mms_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 1100;
  localparam logic [2:0] REG_SPARE = 3'd6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [PADDR_W-1:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  multi_mode_series_smoother dut (.*);

  always #1 clk_i = ~clk_i;

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multi_mode_series_smoother: errors");
      $finish;
    end
  end

  typedef struct {
    logic [31:0] smoothed;
    logic [1:0]  flags;   // [0] mature, [1] divide_fault
  } smooth_out_t;

  smooth_out_t smooth_q[$];
  int          err_cnt = 0;

  // ---------------- smoother model ----------------
  mode_e       m_mode;
  int unsigned m_window, m_alpha, m_beta, m_gamma, m_season;
  int          m_store[MAX_DEPTH];
  longint      m_sum, m_level, m_trend;
  int unsigned m_count, m_ring;
  bit          m_mature;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap40(longint v);
    longint u;
    u = v & ((64'sd1 <<< 40) - 1);
    if (u[39]) u = u - (64'sd1 <<< 40);
    return u;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint blend(int unsigned w, longint old_v, longint new_v);
    longint acc;
    acc = longint'(w) * old_v + (longint'(65536) - longint'(w)) * new_v;
    return with_sign((mag(acc) + 32768) >> 16, acc < 0);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned m;
    m = mag(a) * mag(b);
    m = (m >> FRAC_BITS) + ((m >> (FRAC_BITS - 1)) & 1);
    return with_sign(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint div_q(longint num, longint den, inout bit fault);
    longint unsigned q;
    if (den == 0) begin
      fault = 1'b1;
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    q = mag(num) / mag(den);
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return clamp32(with_sign(q, (num < 0) != (den < 0)));
  endfunction

  function automatic int unsigned ripe_at(int unsigned w);
    return (m_window * w + 32768) >> 16;
  endfunction

  task automatic model_clear();
    foreach (m_store[i]) m_store[i] = 0;
    m_sum = 0; m_level = 0; m_trend = 0;
    m_count = 0; m_ring = 0; m_mature = 1'b0;
  endtask

  task automatic model_write(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_MODE:   begin m_mode = mode_e'(v[1:0]); model_clear(); end
      REG_WINDOW: if (v >= 1 && v <= MAX_DEPTH) m_window = v;
      REG_ALPHA:  if (v <= 65536) m_alpha = v;
      REG_BETA:   if (v <= 65536) m_beta = v;
      REG_GAMMA:  if (v <= 65536) m_gamma = v;
      REG_SEASON: if (v >= MIN_SEASON && v <= MAX_DEPTH) m_season = v;
      default: ;
    endcase
  endtask

  function automatic smooth_out_t smooth_step(logic [31:0] din);
    longint x, y, nl, nt, s, ns;
    longint one;
    bit fault;
    int unsigned pa, pb, p;
    smooth_out_t r;
    x = longint'($signed(din));
    one = 64'sd1 <<< FRAC_BITS;
    y = 0;
    fault = 1'b0;
    if (m_count < 65535) m_count++;
    case (m_mode)
      MODE_MA: begin
        if (m_ring >= m_window) m_ring = 0;
        if (m_mature) begin
          m_sum = wrap40(m_sum + x - m_store[m_ring]);
        end else begin
          if (m_count >= m_window) m_mature = 1'b1;
          m_sum = wrap40(m_sum + x);
        end
        m_store[m_ring] = int'(x);
        m_ring = (m_ring + 1 >= m_window) ? 0 : m_ring + 1;
        y = div_q(m_sum, longint'(m_window), fault);
      end
      MODE_EXP: begin
        if (m_count == ripe_at(m_alpha)) m_mature = 1'b1;
        m_level = (m_count == 1) ? x : clamp32(blend(m_alpha, m_level, x));
        y = m_level;
      end
      MODE_DEXP: begin
        pa = ripe_at(m_alpha);
        pb = ripe_at(m_beta);
        if (m_count == (pa > pb ? pa : pb)) m_mature = 1'b1;
        if (m_count == 1) begin
          m_level = x; m_trend = 0;
        end else begin
          nl = clamp32(blend(m_alpha, m_level, x));
          m_trend = clamp32(blend(m_beta, m_trend, nl - m_level));
          m_level = nl;
        end
        y = clamp32(m_level + m_trend);
      end
      default: begin
        p = m_season;
        if (m_count == 1) begin
          m_level = x; m_trend = 0;
          m_store[0] = int'(x);
          m_sum = wrap40(m_sum + x);
          y = x;
        end else if (m_count <= p) begin
          nl = clamp32(blend(m_alpha, m_level, x));
          nt = clamp32(blend(m_beta, m_trend, nl - m_level));
          m_store[(m_count - 1) % MAX_DEPTH] = int'(x);
          m_sum = wrap40(m_sum + x);
          y = clamp32(nl + nt);
          m_level = nl; m_trend = nt;
        end else begin
          if (!m_mature) begin
            // first item past the buffered period: turn samples into indices
            m_mature = 1'b1;
            for (int i = 0; i < p; i++)
              m_store[i] = int'(div_q(longint'(m_store[i]) * p * one, m_sum, fault));
            m_ring = 0;
          end
          if (m_ring >= p) m_ring = 0;
          s = m_store[m_ring];
          nl = clamp32(blend(m_alpha, m_level + m_trend, div_q(x * one, s, fault)));
          nt = clamp32(blend(m_beta, m_trend, nl - m_level));
          ns = clamp32(blend(m_gamma, s, div_q(x * one, nl, fault)));
          y = clamp32(mul_q(nl + nt, s));
          m_store[m_ring] = int'(ns);
          m_ring = (m_ring + 1 >= p) ? 0 : m_ring + 1;
          m_level = nl; m_trend = nt;
        end
      end
    endcase
    r.smoothed = y[31:0];
    r.flags = {fault, m_mature};
    return r;
  endfunction

  // ---------------- result side ----------------
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    smooth_out_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (smooth_q.size() == 0) begin
        $error("unexpected result beat data=%h user=%b", m_axis_tdata_o, m_axis_tuser_o);
        err_cnt++;
      end else begin
        e = smooth_q.pop_front();
        if (m_axis_tdata_o !== e.smoothed) begin
          $error("smoothed: expected %h actual %h", e.smoothed, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tuser_o[0] !== e.flags[0]) begin
          $error("mature: expected %b actual %b", e.flags[0], m_axis_tuser_o[0]);
          err_cnt++;
        end
        if (m_axis_tuser_o[1] !== e.flags[1]) begin
          $error("divide_fault: expected %b actual %b", e.flags[1], m_axis_tuser_o[1]);
          err_cnt++;
        end
      end
    end
    // one long hold-off, started once
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  // ---------------- stimulus side ----------------
  int sent = 0;

  task automatic send_sample(logic [31:0] v);
    while (idle_on && $urandom_range(99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    smooth_q.push_back(smooth_step(v));
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (smooth_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    drain();
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= PADDR_W'({idx, 2'b00}); pwdata_i <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    model_write(idx, v);
  endtask

  typedef struct {
    bit          is_reg;
    logic [2:0]  idx;
    logic [31:0] val;
    bit          known;
    logic [31:0] exp_data;
    logic [1:0]  exp_user;
  } step_row_t;

  // extremes and special cases; known rows carry their answer
  step_row_t plan[] = '{
    '{1, REG_WINDOW, 32'd1,          0, '0, '0},
    '{1, REG_MODE,   32'(MODE_MA),   0, '0, '0},
    '{0, 3'd0, 32'h7FFF_FFFF,        1, 32'h7FFF_FFFF, 2'b01},
    '{0, 3'd0, 32'h8000_0000,        1, 32'h8000_0000, 2'b01},
    '{0, 3'd0, 32'h0000_0000,        1, 32'h0000_0000, 2'b01},
    '{1, REG_MODE,   32'(MODE_EXP),  0, '0, '0},
    '{0, 3'd0, 32'h0001_2340,        1, 32'h0001_2340, 2'b01},
    '{0, 3'd0, 32'hFFFF_0000,        0, '0, '0},
    '{1, REG_MODE,   32'(MODE_DEXP), 0, '0, '0},
    '{0, 3'd0, 32'h8000_0000,        1, 32'h8000_0000, 2'b01},
    '{0, 3'd0, 32'h7FFF_FFFF,        0, '0, '0},
    '{1, REG_WINDOW, 32'd0,          0, '0, '0},   // out of range, ignored
    '{1, REG_WINDOW, 32'd65,         0, '0, '0},
    '{1, REG_ALPHA,  32'd65537,      0, '0, '0},
    '{1, REG_SEASON, 32'd4,          0, '0, '0},
    '{1, REG_SPARE,  32'd3,          0, '0, '0},   // no such register
    '{1, REG_SEASON, 32'd5,          0, '0, '0},
    '{1, REG_MODE,   32'(MODE_HW),   0, '0, '0},
    '{0, 3'd0, 32'h0,                1, 32'h0, 2'b00},
    '{0, 3'd0, 32'h0,                0, '0, '0},
    '{0, 3'd0, 32'h0,                0, '0, '0},
    '{0, 3'd0, 32'h0,                0, '0, '0},
    '{0, 3'd0, 32'h0,                0, '0, '0},
    '{0, 3'd0, 32'h0,                0, '0, '0},   // zero sum: divide fault
    '{0, 3'd0, 32'h0001_0000,        0, '0, '0}
  };

  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 32'd0;
    if (r < 40) return 32'd65536;
    return $urandom_range(65536);
  endfunction

  function automatic logic [31:0] pick_sample(bit seasonal, int k);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'h0;
    if (r < 20) return $urandom();
    if (seasonal)
      return 32'h000A_0000 + (k % m_season) * 32'h0000_8000 + $urandom_range(4095);
    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
  endfunction

  initial begin
    int phase, n, r;
    m_mode = MODE_MA; m_window = 8; m_alpha = 32768; m_beta = 32768;
    m_gamma = 32768; m_season = 12;
    model_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        reg_write(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].val);
        if (plan[i].known) begin
          // typed answer overrides the model for this row
          smooth_q[$].smoothed = plan[i].exp_data;
          smooth_q[$].flags = plan[i].exp_user;
        end
      end
    end

    phase = 0;
    while (sent < ITEM_GOAL) begin
      r = $urandom_range(99);
      reg_write(REG_WINDOW, r < 25 ? 1 : r < 50 ? MAX_DEPTH : $urandom_range(1, MAX_DEPTH));
      reg_write(REG_ALPHA, pick_weight());
      reg_write(REG_BETA, pick_weight());
      reg_write(REG_GAMMA, pick_weight());
      r = $urandom_range(99);
      reg_write(REG_SEASON, r < 20 ? MIN_SEASON : r < 35 ? MAX_DEPTH :
                $urandom_range(MIN_SEASON, MAX_DEPTH));
      if ($urandom_range(9) == 0) reg_write(REG_ALPHA, 32'd70000);
      reg_write(REG_MODE, phase < 4 ? phase : $urandom_range(3));
      idle_on = (phase != 2);   // one phase runs flat out
      n = (m_mode == MODE_HW) ? m_season + $urandom_range(20, 50) : $urandom_range(20, 70);
      for (int k = 0; k < n; k++) begin
        if (phase == 3 && k == 5) hold_req = 1'b1;
        if (phase == 3 && k == 15) hold_req = 1'b0;
        if (k == n / 2 && m_mode == MODE_MA && $urandom_range(1)) begin
          reg_write(REG_WINDOW, $urandom_range(1, MAX_DEPTH));   // resize mid-stream
        end else if (k == n / 2 && phase == 5) begin
          drain();   // sender waits for every result
        end
        send_sample(pick_sample(m_mode == MODE_HW, k));
      end
      phase++;
    end

    idle_on = 1'b1;
    s_axis_tvalid_i <= 1'b0;
    while (smooth_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && smooth_q.size() == 0) begin
      $display("tb_multi_mode_series_smoother: clean");
    end else begin
      $display("tb_multi_mode_series_smoother: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mms_pkg.sv
hw/rtl/mms_div.sv
hw/rtl/mms_dpath.sv
hw/rtl/mms_ctrl.sv
hw/rtl/multi_mode_series_smoother.sv
dv/tb_multi_mode_series_smoother.sv
